[rtl/heater_hysteresis_controller_top_defines.svh]
// Assertion macros shared by the heater controller RTL.
`ifndef HEATER_HYSTERESIS_CONTROLLER_TOP_DEFINES_SVH
`define HEATER_HYSTERESIS_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HHC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heater controller check failed");

// Next-cycle implication, checked outside reset.
`define HHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heater controller check failed");

`endif

[rtl/hhc_pkg.sv]
// Types and constants for the heater hysteresis controller.
`default_nettype none
package hhc_pkg;

  localparam int TEMP_BITS = 10;
  // Width that holds temperature plus hysteresis without wrap.
  localparam int CMP_BITS  = ((TEMP_BITS > 8) ? TEMP_BITS : 8) + 1;

  typedef logic [TEMP_BITS-1:0] temp_t;
  typedef logic [7:0]           tick8_t;
  typedef logic [15:0]          watch_t;

  localparam logic [1:0] MODE_ENABLE  = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;

  localparam logic [1:0] DIAG_NONE            = 2'd0;
  localparam logic [1:0] DIAG_NOT_WORKING     = 2'd1;
  localparam logic [1:0] DIAG_NOT_TURNING_OFF = 2'd2;

  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_HYST      = 2'd1;
  localparam logic [1:0] REG_OFF_DELAY = 2'd2;
  localparam logic [1:0] REG_WATCH     = 2'd3;

  localparam temp_t  TARGET_RESET    = '0;
  localparam tick8_t HYST_RESET      = 8'd3;
  localparam tick8_t OFF_DELAY_RESET = 8'd2;
  localparam watch_t WATCH_RESET     = 16'd900;

endpackage
`default_nettype wire

[rtl/hhc_ifs.sv]
// Valid/ready channel interfaces for control ticks and results.
`default_nettype none
interface hhc_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic                fan_running;
  logic                preheating;
  logic                door_closed;
  hhc_pkg::temp_t      oven_temp;

  modport source (output valid, mode, fan_running, preheating, door_closed, oven_temp,
                  input ready);
  modport sink   (input valid, mode, fan_running, preheating, door_closed, oven_temp,
                  output ready);
endinterface

interface hhc_out_if;
  logic                valid;
  logic                ready;
  logic                heater_drive;
  logic                door_open_request;
  logic [1:0]          diag_event;
  hhc_pkg::temp_t      diag_temp;

  modport source (output valid, heater_drive, door_open_request, diag_event, diag_temp,
                  input ready);
  modport sink   (input valid, heater_drive, door_open_request, diag_event, diag_temp,
                  output ready);
endinterface
`default_nettype wire

[rtl/heater_hysteresis_controller_top.sv]
// Top level of the on/off heater thermostat with hysteresis and watchdogs.
//
//   channel | direction | handshake         | beat contents
//   in_ch   | in        | valid/ready       | mode, fan, preheat, door, oven_temp
//   out_ch  | out       | valid/ready       | heater_drive, door request, diag
//   cfg_*   | in        | APB, pready high  | four setpoint/timing registers
//
// A tick beat is captured in an input register, evaluated combinationally against the
// thermostat state and lands in the result register. One beat per cycle is sustained
// while the result is not stalled; state updates when a beat enters the result stage.
// Reset (rst_n low, synchronous) clears both stages and loads register defaults.
// A stalled result holds both stages; the input register still fills if it is empty.
`default_nettype none
`include "heater_hysteresis_controller_top_defines.svh"
module heater_hysteresis_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hhc_in_if.sink                             in_ch,
  hhc_out_if.source                          out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [hhc_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready
);

  // Configuration registers
  hhc_pkg::temp_t  target_r;
  hhc_pkg::tick8_t hyst_r;
  hhc_pkg::tick8_t off_delay_ticks_r;
  hhc_pkg::watch_t watch_ticks_r;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r          <= hhc_pkg::TARGET_RESET;
      hyst_r            <= hhc_pkg::HYST_RESET;
      off_delay_ticks_r <= hhc_pkg::OFF_DELAY_RESET;
      watch_ticks_r     <= hhc_pkg::WATCH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hhc_pkg::REG_TARGET:    target_r          <= cfg_pwdata[hhc_pkg::TEMP_BITS-1:0];
        hhc_pkg::REG_HYST:      hyst_r            <= cfg_pwdata[7:0];
        hhc_pkg::REG_OFF_DELAY: off_delay_ticks_r <= cfg_pwdata[7:0];
        hhc_pkg::REG_WATCH:     watch_ticks_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hhc_pkg::REG_TARGET:    cfg_prdata = {{(32-hhc_pkg::TEMP_BITS){1'b0}}, target_r};
      hhc_pkg::REG_HYST:      cfg_prdata = {24'd0, hyst_r};
      hhc_pkg::REG_OFF_DELAY: cfg_prdata = {24'd0, off_delay_ticks_r};
      hhc_pkg::REG_WATCH:     cfg_prdata = {16'd0, watch_ticks_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // Pipeline control
  logic s0_valid_r;
  logic out_valid_r;
  logic advance;
  logic in_fire;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s0_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;

  // Input register
  logic [1:0]     s0_mode_r;
  logic           s0_fan_r;
  logic           s0_preheat_r;
  logic           s0_door_r;
  hhc_pkg::temp_t s0_temp_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_mode_r    <= in_ch.mode;
      s0_fan_r     <= in_ch.fan_running;
      s0_preheat_r <= in_ch.preheating;
      s0_door_r    <= in_ch.door_closed;
      s0_temp_r    <= in_ch.oven_temp;
    end
  end

  // Thermostat state
  logic            heater_on_r,      heater_on_nxt;
  hhc_pkg::tick8_t off_delay_left_r, off_delay_left_nxt;
  hhc_pkg::watch_t on_watch_left_r,  on_watch_left_nxt;
  hhc_pkg::watch_t off_watch_left_r, off_watch_left_nxt;
  logic            door_req;
  logic [1:0]      diag;

  logic [hhc_pkg::CMP_BITS-1:0] temp_plus_hyst;
  logic [hhc_pkg::CMP_BITS-1:0] target_wide;
  logic                         above_target;
  logic                         below_band;

  // temp < target - hyst, rewritten as temp + hyst < target to stay unsigned.
  assign temp_plus_hyst = hhc_pkg::CMP_BITS'(s0_temp_r) + hhc_pkg::CMP_BITS'(hyst_r);
  assign target_wide    = hhc_pkg::CMP_BITS'(target_r);
  assign above_target   = s0_temp_r > target_r;
  assign below_band     = temp_plus_hyst < target_wide;

  always_comb begin
    heater_on_nxt      = heater_on_r;
    off_delay_left_nxt = off_delay_left_r;
    on_watch_left_nxt  = on_watch_left_r;
    off_watch_left_nxt = off_watch_left_r;
    door_req           = 1'b0;
    diag               = hhc_pkg::DIAG_NONE;
    case (s0_mode_r)
      hhc_pkg::MODE_ENABLE: begin
        if (!s0_fan_r) begin
          heater_on_nxt = 1'b0;
        end else if (above_target) begin
          if (off_delay_left_r != 8'd0) begin
            off_delay_left_nxt = off_delay_left_r - 8'd1;
          end else begin
            heater_on_nxt     = 1'b0;
            on_watch_left_nxt = watch_ticks_r;
            if (off_watch_left_r != 16'd0) begin
              off_watch_left_nxt = off_watch_left_r - 16'd1;
            end else begin
              diag               = hhc_pkg::DIAG_NOT_TURNING_OFF;
              off_watch_left_nxt = watch_ticks_r;
            end
            door_req = s0_preheat_r && s0_door_r;
          end
        end else if (below_band) begin
          heater_on_nxt      = 1'b1;
          off_delay_left_nxt = off_delay_ticks_r;
          off_watch_left_nxt = watch_ticks_r;
          if (on_watch_left_r != 16'd0) begin
            on_watch_left_nxt = on_watch_left_r - 16'd1;
          end else begin
            // below_band already implies the temperature is under target.
            diag              = hhc_pkg::DIAG_NOT_WORKING;
            on_watch_left_nxt = watch_ticks_r;
          end
        end
      end
      hhc_pkg::MODE_DISABLE: begin
        heater_on_nxt      = 1'b0;
        on_watch_left_nxt  = watch_ticks_r;
        off_watch_left_nxt = watch_ticks_r;
      end
      default: ;
    endcase
  end

  logic step;
  assign step = s0_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      heater_on_r      <= 1'b0;
      off_delay_left_r <= hhc_pkg::OFF_DELAY_RESET;
      on_watch_left_r  <= hhc_pkg::WATCH_RESET;
      off_watch_left_r <= hhc_pkg::WATCH_RESET;
    end else begin
      if (in_ch.ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s0_valid_r;
      end
      if (step) begin
        heater_on_r      <= heater_on_nxt;
        off_delay_left_r <= off_delay_left_nxt;
        on_watch_left_r  <= on_watch_left_nxt;
        off_watch_left_r <= off_watch_left_nxt;
      end
    end
  end

  // Result register
  logic           res_heater_r;
  logic           res_door_r;
  logic [1:0]     res_diag_r;
  hhc_pkg::temp_t res_temp_r;

  always_ff @(posedge clk) begin
    if (step) begin
      res_heater_r <= heater_on_nxt;
      res_door_r   <= door_req;
      res_diag_r   <= diag;
      res_temp_r   <= (diag != hhc_pkg::DIAG_NONE) ? s0_temp_r : '0;
    end
  end

  assign out_ch.heater_drive      = res_heater_r;
  assign out_ch.door_open_request = res_door_r;
  assign out_ch.diag_event        = res_diag_r;
  assign out_ch.diag_temp         = res_temp_r;

  `HHC_ASSERT_NOW(a_diag_temp_zero,
    out_valid_r && (res_diag_r == hhc_pkg::DIAG_NONE), res_temp_r == '0)
  `HHC_ASSERT_NOW(a_door_req_heater_off, out_valid_r && res_door_r, !res_heater_r)
  `HHC_ASSERT_NOW(a_not_working_heater_on,
    out_valid_r && (res_diag_r == hhc_pkg::DIAG_NOT_WORKING), res_heater_r)
  `HHC_ASSERT_NEXT(a_stage_holds, s0_valid_r && !advance, s0_valid_r)

endmodule
`default_nettype wire
